@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication property on the rising clock edge, disabled while in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication property
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ rtl/hqi_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hqi_pkg
// Constants, codes and types of the histogram quantile interpolator.
// ---------------------------------------------------------------------------
package hqi_pkg;
    localparam int MaxBuckets = 16;
    localparam int IdxW       = $clog2(MaxBuckets);
    localparam int FillW      = $clog2(MaxBuckets + 1);

    localparam logic [2:0] CfgQCount = 3'd0;
    localparam logic [2:0] CfgQA     = 3'd1;
    localparam logic [2:0] CfgQD     = 3'd4;

    localparam logic [1:0] StOk      = 2'd0;
    localparam logic [1:0] StBadQ    = 2'd1;
    localparam logic [1:0] StNoData  = 2'd2;
    localparam logic [1:0] StTooMany = 2'd3;

    typedef enum logic [3:0] {
        S_LOAD, S_CHECK, S_SCAN, S_BND_RD, S_QT, S_TEST, S_WALK,
        S_DIV, S_FIX, S_EMIT, S_DONE
    } t_state;
endpackage

@@ rtl/histogram_quantile_interpolator_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// histogram_quantile_interpolator_top
// Bucket store with cumulative walk and linear interpolation per quantile.
// ---------------------------------------------------------------------------
// Buckets are taken one per cycle while loading into three synchronous
// memories (count, bound, open flag; 16 entries, registered read). The item
// marked tlast starts the walk: a scan for the first open bucket (one cycle a
// bucket), a read of the last finite bound, then per quantile a step to form
// the target, a test and a walk step for each bucket walked, and for an
// interpolated value a 32-step shift-and-add divider (one bit of the bound
// difference a cycle) and a final step to apply the sign. Each result waits
// while the result side stalls. No item is taken until the final result has
// left the output register.
module histogram_quantile_interpolator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // bucket_count[31:0], upper_bound[63:32]
    input  logic        s_axis_tuser,   // is_open
    input  logic        s_axis_tlast,   // last_bucket
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // quantile_index[1:0], estimate[33:2], status[35:34]
    output logic        m_axis_tlast,   // last_result
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);
    import hqi_pkg::*;

    logic [31:0] r_cnt_mem [MaxBuckets];
    logic [31:0] r_bnd_mem [MaxBuckets];
    logic        r_opn_mem [MaxBuckets];
    logic [31:0] r_cnt_rd, r_bnd_rd;
    logic        r_opn_rd;

    logic [2:0]  r_qcnt;
    logic [16:0] r_q [4];

    t_state           r_state, n_state;
    logic [FillW-1:0] r_fill;
    logic [35:0]      r_total;
    logic             r_ovf, r_last_open;
    logic [FillW-1:0] r_nfin;
    logic [IdxW-1:0]  r_addr, n_addr;
    logic [FillW-1:0] r_i;
    logic [2:0]       r_nq;
    logic [1:0]       r_status;
    logic [2:0]       r_next;
    logic [35:0]      r_cum, r_before;
    logic [31:0]      r_c, r_upper, r_lower, r_last_fin;
    logic [52:0]      r_qt;
    logic             r_neg;
    logic [31:0]      r_diff;
    logic [47:0]      r_num, r_den, r_rem;
    logic [31:0]      r_quo;
    logic [4:0]       r_step;
    logic [31:0]      r_est;
    logic             r_ovalid;
    logic [1:0]       r_oidx, r_ost;
    logic [31:0]      r_oest;
    logic             r_olast;

    logic             w_acc, w_wr, w_op, w_bad, w_out_free, w_emit;
    logic             w_reached, w_scan_end, w_ge1, w_ge2;
    logic [2:0]       w_nq;
    logic [FillW-1:0] w_nfin;
    logic [52:0]      w_qt, w_num;
    logic [49:0]      w_sum, w_rem_next;
    logic [1:0]       w_digit;

    assign w_out_free    = !r_ovalid || m_axis_tready;
    assign w_emit        = (r_state == S_EMIT) && w_out_free;
    assign s_axis_tready = (r_state == S_LOAD);
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_wr          = w_acc && (r_fill < FillW'(MaxBuckets));
    assign w_op          = s_axis_tuser || ((r_fill != '0) && r_last_open);
    assign w_qt          = 53'(r_q[r_next[1:0]]) * 53'(r_total);
    assign w_reached     = ({1'b0, r_cum, 16'd0} >= r_qt);
    assign w_nfin        = r_opn_rd ? r_nfin : r_nfin + 1'b1;
    assign w_scan_end    = r_opn_rd || (w_nfin == r_fill);
    assign w_num         = r_qt - {1'b0, r_before, 16'd0};

    // Divider step: remainder stays below den, so one digit of 0, 1 or 2
    assign w_sum      = {1'b0, r_rem, 1'b0} + {2'b0, (r_diff[31] ? r_num : 48'd0)};
    assign w_ge2      = w_sum >= {1'b0, r_den, 1'b0};
    assign w_ge1      = w_sum >= {2'b0, r_den};
    assign w_digit    = w_ge2 ? 2'd2 : (w_ge1 ? 2'd1 : 2'd0);
    assign w_rem_next = w_ge2 ? w_sum - {1'b0, r_den, 1'b0}
                              : (w_ge1 ? w_sum - {2'b0, r_den} : w_sum);

    always_comb begin
        w_nq  = (r_qcnt > 3'd4) ? 3'd4 : r_qcnt;
        w_bad = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if (3'(k) < w_nq && (r_q[k] == 17'd0 || r_q[k] > 17'd65536)) w_bad = 1'b1;
        end
        for (int k = 1; k < 4; k++) begin
            if (3'(k) < w_nq && r_q[k] < r_q[k-1]) w_bad = 1'b1;
        end
        // An empty list still answers once, as invalid
        if (r_qcnt == 3'd0) begin
            w_nq  = 3'd1;
            w_bad = 1'b1;
        end
    end

    // Memories: one write and one read a cycle
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_cnt_mem[r_fill[IdxW-1:0]] <= s_axis_tdata[31:0];
            r_bnd_mem[r_fill[IdxW-1:0]] <= s_axis_tdata[63:32];
            r_opn_mem[r_fill[IdxW-1:0]] <= w_op;
        end
        r_cnt_rd <= r_cnt_mem[n_addr];
        r_bnd_rd <= r_bnd_mem[n_addr];
        r_opn_rd <= r_opn_mem[n_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qcnt <= 3'd3;
            r_q[0] <= 17'd32768;
            r_q[1] <= 17'd58982;
            r_q[2] <= 17'd64880;
            r_q[3] <= 17'd65536;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CfgQCount) r_qcnt <= i_cfg_data[2:0];
            else if (i_cfg_index inside {[CfgQA:CfgQD]})
                r_q[2'(i_cfg_index - CfgQA)] <= i_cfg_data;
        end
    end

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        case (r_state)
            S_LOAD:   if (w_acc && s_axis_tlast) n_state = S_CHECK;
            S_CHECK:  begin
                n_addr = '0;
                if (w_bad || r_ovf || r_total == '0) n_state = S_EMIT;
                else n_state = S_SCAN;
            end
            S_SCAN:   begin
                if (w_scan_end) begin
                    n_state = S_BND_RD;
                    n_addr  = w_nfin[IdxW-1:0] - 1'b1;
                end else begin
                    n_addr  = r_addr + 1'b1;
                end
            end
            S_BND_RD: n_state = (r_nfin == '0) ? S_EMIT : S_QT;
            S_QT:     n_state = S_TEST;
            S_TEST:   begin
                if (!w_reached) begin
                    if (r_i == r_fill) n_state = S_EMIT;
                    else begin
                        n_state = S_WALK;
                        n_addr  = r_i[IdxW-1:0];
                    end
                end else if (r_i > r_nfin || r_c == '0) n_state = S_EMIT;
                else n_state = S_DIV;
            end
            S_WALK:   n_state = S_TEST;
            S_DIV:    if (r_step == 5'd31) n_state = S_FIX;
            S_FIX:    n_state = S_EMIT;
            S_EMIT:   if (w_out_free) begin
                if (r_next + 1'b1 == r_nq) n_state = S_DONE;
                else if (r_status == StOk) n_state = S_QT;
            end
            // Hold off new buckets until the final result has left
            S_DONE:   if (w_out_free) n_state = S_LOAD;
            default:  n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_fill  <= '0;
            r_total <= '0;
            r_ovf   <= 1'b0;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            case (r_state)
                S_LOAD: if (w_acc) begin
                    if (w_wr) begin
                        r_fill      <= r_fill + 1'b1;
                        r_total     <= r_total + 36'(s_axis_tdata[31:0]);
                        r_last_open <= w_op;
                    end else r_ovf <= 1'b1;
                end
                S_CHECK: begin
                    r_nq    <= w_nq;
                    r_next  <= '0;
                    r_nfin  <= '0;
                    r_cum   <= '0;
                    r_i     <= '0;
                    r_upper <= '0;
                    if (w_bad) r_status <= StBadQ;
                    else if (r_ovf) r_status <= StTooMany;
                    else if (r_total == '0) r_status <= StNoData;
                    else r_status <= StOk;
                end
                S_SCAN: r_nfin <= w_nfin;
                S_BND_RD: begin
                    r_last_fin <= r_bnd_rd;
                    if (r_nfin == '0) r_status <= StNoData;
                end
                S_QT: r_qt <= w_qt;
                S_WALK: begin
                    // Take the next bucket into the running sum
                    r_c      <= r_cnt_rd;
                    r_lower  <= r_upper;
                    r_upper  <= r_bnd_rd;
                    r_before <= r_cum;
                    r_cum    <= r_cum + 36'(r_cnt_rd);
                    r_i      <= r_i + 1'b1;
                end
                S_TEST: begin
                    r_est  <= r_last_fin;
                    r_num  <= w_num[47:0];
                    r_den  <= {r_c, 16'd0};
                    r_neg  <= r_upper < r_lower;
                    r_diff <= (r_upper < r_lower) ? r_lower - r_upper : r_upper - r_lower;
                    r_rem  <= '0;
                    r_quo  <= '0;
                    r_step <= '0;
                end
                S_DIV: begin
                    r_diff <= {r_diff[30:0], 1'b0};
                    r_rem  <= w_rem_next[47:0];
                    r_quo  <= {r_quo[30:0], 1'b0} + {30'd0, w_digit};
                    r_step <= r_step + 1'b1;
                end
                S_FIX: begin
                    if (r_neg)
                        r_est <= r_lower - r_quo - {31'd0, (r_rem != '0)};
                    else
                        r_est <= r_lower + r_quo;
                end
                S_EMIT: if (w_out_free) r_next <= r_next + 1'b1;
                S_DONE: begin
                    r_fill  <= '0;
                    r_total <= '0;
                    r_ovf   <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_emit) begin
            r_ovalid <= 1'b1;
            r_oidx   <= r_next[1:0];
            r_oest   <= (r_status == StOk) ? r_est : 32'd0;
            r_ost    <= r_status;
            r_olast  <= (r_next + 1'b1 == r_nq);
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'd0, r_ost, r_oest, r_oidx};
    assign m_axis_tlast  = r_olast;
endmodule

@@ rtl/hqi_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// hqi_checker
// Port-level checks of the quantile interpolator, bound to the top level.
// ---------------------------------------------------------------------------
module hqi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result item dropped while stalled")
    `ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[35:34] != 2'd0,
        m_axis_tdata[33:2] == 32'd0, "error result carries an estimate")
    `ASSERT_IMPL(a_no_load, i_clk, i_rst_n, m_axis_tvalid,
        !s_axis_tready, "bucket taken while results are pending")
    `ASSERT_NEXT(a_idx_step, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tready && !m_axis_tlast && m_axis_tdata[1:0] == 2'd0,
        !m_axis_tvalid || m_axis_tdata[1:0] == 2'd1, "quantile index skipped")
endmodule

bind histogram_quantile_interpolator_top hqi_checker u_hqi_checker (.*);
